/* design/ctab_pkg.sv */
// ----------------------------------------------------------------------------
// ctab_pkg - shared types and constants of the clipped tinted alpha blitter
// Configuration register set, register indexes, mode codes and the exact
// divide-by-255 helper used by the blend datapath.
// ----------------------------------------------------------------------------
package ctab_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_CLIP_MIN_X  = 3'd1;
    localparam logic [2:0] REG_CLIP_MIN_Y  = 3'd2;
    localparam logic [2:0] REG_CLIP_MAX_X  = 3'd3;
    localparam logic [2:0] REG_CLIP_MAX_Y  = 3'd4;
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd5;
    localparam logic [2:0] REG_PAINT_COLOR = 3'd6;

    // Colour modes; the upper code also means fill
    localparam logic [1:0] MODE_BLEND = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [7:0] CHAN_MAX = 8'hff;

    // Depth of the queue between classifier and colour pipeline
    localparam int QUEUE_DEPTH = 4;

    // Configuration register set
    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] clip_min_x;
        logic [11:0] clip_min_y;
        logic [11:0] clip_max_x;
        logic [11:0] clip_max_y;
        logic [12:0] frame_width;
        logic [31:0] paint_color;
    } cfg_t;

    // floor(v / 255), exact for v up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

/* design/ctab_queue.sv */
// ----------------------------------------------------------------------------
// ctab_queue - short register queue between classifier and colour pipeline
// First-in first-out store with the oldest entry always on rdata.
// ----------------------------------------------------------------------------
module ctab_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  logic [DATA_W-1:0] wdata,
    output logic              q_full,
    input  logic              rd,
    output logic [DATA_W-1:0] rdata,
    output logic              q_empty
);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Store the incoming beat at the tail
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/ctab_front.sv */
// ----------------------------------------------------------------------------
// ctab_front - input side of the blitter: accept and classify pixels
// Tests each coordinate against the framebuffer bounds and the clip
// rectangle, narrows it and hands the packed beat to the queue.
// ----------------------------------------------------------------------------
module ctab_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int YW        = $clog2(MAX_HEIGHT),
    localparam int ENTRY_W   = 1 + XW + YW + 32 + 24 + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctab_pkg::cfg_t     cfg,
    input  logic signed [13:0] dest_x,
    input  logic signed [13:0] dest_y,
    input  logic [31:0]        src_argb,
    input  logic [23:0]        dst_pixel,
    input  logic               last_in,
    input  logic               push,
    output logic               full,
    output logic               q_write,
    output logic [ENTRY_W-1:0] q_data,
    input  logic               q_full
);

    logic               valid_reg;
    logic               valid_next;
    logic [ENTRY_W-1:0] entry_reg;
    logic               load;
    logic               x_ok;
    logic               y_ok;
    logic               in_clip;

    // Bounds and clip test; a negative coordinate is rejected by its sign bit
    always_comb
    begin
        x_ok = !dest_x[13]
            && ({1'b0, dest_x[12:0]} < 14'(MAX_WIDTH))
            && (dest_x[12:0] >= {1'b0, cfg.clip_min_x})
            && (dest_x[12:0] <= {1'b0, cfg.clip_max_x});
        y_ok = !dest_y[13]
            && ({1'b0, dest_y[12:0]} < 14'(MAX_HEIGHT))
            && (dest_y[12:0] >= {1'b0, cfg.clip_min_y})
            && (dest_y[12:0] <= {1'b0, cfg.clip_max_y});
        in_clip = x_ok && y_ok;
    end

    // Hold the classified beat until the queue takes it
    assign full       = valid_reg && q_full;
    assign load       = push && !full;
    assign q_write    = valid_reg;
    assign q_data     = entry_reg;
    assign valid_next = load || (valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= {in_clip, dest_x[XW-1:0], dest_y[YW-1:0],
                          src_argb, dst_pixel, last_in};
        end
    end

endmodule

/* design/ctab_back.sv */
// ----------------------------------------------------------------------------
// ctab_back - colour and address pipeline of the blitter
// Four register stages: tint products and address, tinted source, blend
// sum, then the output register with the mode select. The whole pipeline
// advances whenever the output register is free or being popped.
// ----------------------------------------------------------------------------
module ctab_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int YW        = $clog2(MAX_HEIGHT),
    localparam int ENTRY_W   = 1 + XW + YW + 32 + 24 + 1,
    localparam int PW        = YW + 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctab_pkg::cfg_t     cfg,
    input  logic [ENTRY_W-1:0] q_data,
    input  logic               q_empty,
    output logic               q_read,
    output logic               empty,
    input  logic               pop,
    output logic               write_enable,
    output logic [23:0]        address,
    output logic [31:0]        color_out,
    output logic               last_out
);

    // Unpacked queue head
    logic          h_we;
    logic [XW-1:0] h_x;
    logic [YW-1:0] h_y;
    logic [31:0]   h_src;
    logic [23:0]   h_dst;
    logic          h_last;

    assign {h_we, h_x, h_y, h_src, h_dst, h_last} = q_data;

    logic advance;

    // Stage 1: tint products and linear address
    logic             s1_valid_reg;
    logic             s1_we_reg;
    logic [23:0]      s1_addr_reg;
    logic [31:0]      s1_src_reg;
    logic [23:0]      s1_dst_reg;
    logic             s1_last_reg;
    logic [2:0][15:0] s1_prod_reg;
    logic [2:0][15:0] s1_prod_next;
    logic [PW-1:0]    row_base;
    logic [23:0]      s1_addr_next;

    // Stage 2: tinted source channels
    logic            s2_valid_reg;
    logic            s2_we_reg;
    logic [23:0]     s2_addr_reg;
    logic [31:0]     s2_src_reg;
    logic [23:0]     s2_dst_reg;
    logic            s2_last_reg;
    logic [2:0][7:0] s2_tint_reg;
    logic [2:0][7:0] s2_tint_next;

    // Stage 3: blend sums
    logic             s3_valid_reg;
    logic             s3_we_reg;
    logic [23:0]      s3_addr_reg;
    logic [31:0]      s3_src_reg;
    logic             s3_last_reg;
    logic [2:0][15:0] s3_sum_reg;
    logic [2:0][15:0] s3_sum_next;
    logic [7:0]       alpha2;
    logic [7:0]       inv_alpha2;

    // Output register
    logic        out_valid_reg;
    logic        out_we_reg;
    logic [23:0] out_addr_reg;
    logic [31:0] out_color_reg;
    logic        out_last_reg;
    logic [31:0] out_color_next;
    logic [23:0] blend_rgb;

    assign advance = !out_valid_reg || pop;
    assign q_read  = advance && !q_empty;

    assign empty        = !out_valid_reg;
    assign write_enable = out_we_reg;
    assign address      = out_addr_reg;
    assign color_out    = out_color_reg;
    assign last_out     = out_last_reg;

    // Stage 1 logic: source times tint per channel, row base plus column
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s1_prod_next[c] = 16'(h_src[8*c +: 8]) * 16'(cfg.paint_color[8*c +: 8]);
        end
        row_base     = PW'(h_y) * PW'(cfg.frame_width);
        s1_addr_next = 24'(row_base) + 24'(h_x);
    end

    // Stage 2 logic: scale the tint products back to a channel
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s2_tint_next[c] = ctab_pkg::div255(s1_prod_reg[c]);
        end
    end

    // Stage 3 logic: weighted sum of destination and tinted source
    always_comb
    begin
        alpha2     = s2_src_reg[31:24];
        inv_alpha2 = ctab_pkg::CHAN_MAX - alpha2;
        for (int c = 0; c < 3; c++)
        begin
            s3_sum_next[c] = 16'(16'(s2_dst_reg[8*c +: 8]) * 16'(inv_alpha2)
                               + 16'(s2_tint_reg[c]) * 16'(alpha2));
        end
    end

    // Output logic: final divide and mode select, zero when clipped
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            blend_rgb[8*c +: 8] = ctab_pkg::div255(s3_sum_reg[c]);
        end
        case (cfg.mode)
            ctab_pkg::MODE_BLEND: out_color_next = {8'h00, blend_rgb};
            ctab_pkg::MODE_COPY:  out_color_next = s3_src_reg;
            ctab_pkg::MODE_FILL:  out_color_next = cfg.paint_color;
            default:              out_color_next = cfg.paint_color;
        endcase
        if (!s3_we_reg)
        begin
            out_color_next = '0;
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_we_reg   <= h_we;
            s1_addr_reg <= s1_addr_next;
            s1_src_reg  <= h_src;
            s1_dst_reg  <= h_dst;
            s1_last_reg <= h_last;
            s1_prod_reg <= s1_prod_next;

            s2_we_reg   <= s1_we_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_src_reg  <= s1_src_reg;
            s2_dst_reg  <= s1_dst_reg;
            s2_last_reg <= s1_last_reg;
            s2_tint_reg <= s2_tint_next;

            s3_we_reg   <= s2_we_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_src_reg  <= s2_src_reg;
            s3_last_reg <= s2_last_reg;
            s3_sum_reg  <= s3_sum_next;

            out_we_reg    <= s3_we_reg && s3_valid_reg;
            out_addr_reg  <= s3_we_reg ? s3_addr_reg : 24'd0;
            out_color_reg <= out_color_next;
            out_last_reg  <= s3_last_reg;
        end
    end

endmodule

/* design/clipped_tinted_alpha_blit.sv */
// ----------------------------------------------------------------------------
// clipped_tinted_alpha_blit - clipped, tinted alpha-blending pixel writer
// Top level: configuration registers, classifier, queue and colour pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter as beats on the input queue port: drive dest_x, dest_y,
//   src_argb, dst_pixel and last_in with push high; a beat is taken at a
//   clock edge where full is low. Results leave through the output queue
//   port: while empty is low the oldest result sits on write_enable,
//   address, color_out and last_out, and pop takes it.
//   Each pixel gives exactly one result, in input order. A result passes
//   the classifier register, a queue slot, then three pipeline stages
//   into the output register. Throughput is one pixel per clock while
//   results are popped, with the single row multiplier (row index times
//   13-bit row length) and the channel multipliers all fully pipelined.
//   When the receiver stops popping, the pipeline holds, the four-entry
//   queue fills, then the classifier register, and only then full rises.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high. Write them only while no pixel is in flight.
//   Reset (rst_n low) empties every stage and restores the register
//   defaults: blend mode, full 4096 by 4096 clip, row length 4096, white tint.
// ----------------------------------------------------------------------------
module clipped_tinted_alpha_blit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // pixel input
    input  logic signed [13:0] dest_x,
    input  logic signed [13:0] dest_y,
    input  logic [31:0]        src_argb,
    input  logic [23:0]        dst_pixel,
    input  logic               last_in,
    input  logic               push,
    output logic               full,
    // result output
    output logic               write_enable,
    output logic [23:0]        address,
    output logic [31:0]        color_out,
    output logic               last_out,
    output logic               empty,
    input  logic               pop
);

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int ENTRY_W = 1 + XW + YW + 32 + 24 + 1;

    ctab_pkg::cfg_t     cfg_reg;
    logic               q_write;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_full;
    logic               q_read;
    logic [ENTRY_W-1:0] q_rdata;
    logic               q_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= ctab_pkg::MODE_BLEND;
            cfg_reg.clip_min_x  <= 12'd0;
            cfg_reg.clip_min_y  <= 12'd0;
            cfg_reg.clip_max_x  <= 12'd4095;
            cfg_reg.clip_max_y  <= 12'd4095;
            cfg_reg.frame_width <= 13'd4096;
            cfg_reg.paint_color <= 32'h00ff_ffff;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ctab_pkg::REG_MODE:        cfg_reg.mode        <= cfg_data[1:0];
                ctab_pkg::REG_CLIP_MIN_X:  cfg_reg.clip_min_x  <= cfg_data[11:0];
                ctab_pkg::REG_CLIP_MIN_Y:  cfg_reg.clip_min_y  <= cfg_data[11:0];
                ctab_pkg::REG_CLIP_MAX_X:  cfg_reg.clip_max_x  <= cfg_data[11:0];
                ctab_pkg::REG_CLIP_MAX_Y:  cfg_reg.clip_max_y  <= cfg_data[11:0];
                ctab_pkg::REG_FRAME_WIDTH: cfg_reg.frame_width <= cfg_data[12:0];
                ctab_pkg::REG_PAINT_COLOR: cfg_reg.paint_color <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Accept and classify
    ctab_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .dest_x    (dest_x),
        .dest_y    (dest_y),
        .src_argb  (src_argb),
        .dst_pixel (dst_pixel),
        .last_in   (last_in),
        .push      (push),
        .full      (full),
        .q_write   (q_write),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    // Decouple the two sides
    ctab_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (ctab_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_read),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    // Colour and address pipeline
    ctab_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_data       (q_rdata),
        .q_empty      (q_empty),
        .q_read       (q_read),
        .empty        (empty),
        .pop          (pop),
        .write_enable (write_enable),
        .address      (address),
        .color_out    (color_out),
        .last_out     (last_out)
    );

endmodule

/* tb/sv/clipped_tinted_alpha_blit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_tinted_alpha_blit_checker - pixel write predictor and scoreboard
// Watches the configuration, input and result channels of the blitter. It
// keeps its own copy of the registers, predicts the pixel write for every
// accepted input beat and compares every accepted result beat, in order,
// with the oldest prediction. Hands the failure count and the number of
// outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module clipped_tinted_alpha_blit_checker #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [13:0] dest_x,
    input  logic signed [13:0] dest_y,
    input  logic [31:0]        src_argb,
    input  logic [23:0]        dst_pixel,
    input  logic               last_in,
    input  logic               push,
    input  logic               full,
    input  logic               write_enable,
    input  logic [23:0]        address,
    input  logic [31:0]        color_out,
    input  logic               last_out,
    input  logic               empty,
    input  logic               pop,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct packed {
        logic        we;
        logic [23:0] addr;
        logic [31:0] color;
        logic        last;
    } pixel_write_t;

    ctab_pkg::cfg_t regs;
    pixel_write_t   expected_writes[$];

    // Tint one source channel, then blend it over the destination channel
    function automatic logic [7:0] tint_blend(input int s, input int t, input int d,
                                              input int a);
        int tinted;
        tinted = (s * t) / 255;
        return 8'((d * (255 - a) + tinted * a) / 255);
    endfunction

    function automatic pixel_write_t predict_pixel_write(input ctab_pkg::cfg_t c,
                                                         input logic signed [13:0] x,
                                                         input logic signed [13:0] y,
                                                         input logic [31:0] src,
                                                         input logic [23:0] dst,
                                                         input logic last);
        pixel_write_t w;
        int xi;
        int yi;
        int a;
        int unsigned lin;
        xi = x;
        yi = y;
        a = src[31:24];
        w = '0;
        w.last = last;
        w.we = xi >= 0 && yi >= 0 && xi < MAX_WIDTH && yi < MAX_HEIGHT &&
               xi >= int'(c.clip_min_x) && xi <= int'(c.clip_max_x) &&
               yi >= int'(c.clip_min_y) && yi <= int'(c.clip_max_y);
        if (w.we)
        begin
            lin = yi * int'(c.frame_width) + xi;
            w.addr = lin[23:0];
            if (c.mode == ctab_pkg::MODE_BLEND)
            begin
                w.color = {8'h00,
                           tint_blend(src[23:16], c.paint_color[23:16], dst[23:16], a),
                           tint_blend(src[15:8], c.paint_color[15:8], dst[15:8], a),
                           tint_blend(src[7:0], c.paint_color[7:0], dst[7:0], a)};
            end
            else if (c.mode == ctab_pkg::MODE_COPY)
                w.color = src;
            else
                w.color = c.paint_color;
        end
        return w;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
    endtask

    // Track registers, predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_write_t want;
        logic         bad;
        if (!rst_n)
        begin
            regs.mode        = ctab_pkg::MODE_BLEND;
            regs.clip_min_x  = 12'd0;
            regs.clip_min_y  = 12'd0;
            regs.clip_max_x  = 12'd4095;
            regs.clip_max_y  = 12'd4095;
            regs.frame_width = 13'd4096;
            regs.paint_color = 32'h00ff_ffff;
            expected_writes.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            bad = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ctab_pkg::REG_MODE:        regs.mode        = cfg_data[1:0];
                    ctab_pkg::REG_CLIP_MIN_X:  regs.clip_min_x  = cfg_data[11:0];
                    ctab_pkg::REG_CLIP_MIN_Y:  regs.clip_min_y  = cfg_data[11:0];
                    ctab_pkg::REG_CLIP_MAX_X:  regs.clip_max_x  = cfg_data[11:0];
                    ctab_pkg::REG_CLIP_MAX_Y:  regs.clip_max_y  = cfg_data[11:0];
                    ctab_pkg::REG_FRAME_WIDTH: regs.frame_width = cfg_data[12:0];
                    ctab_pkg::REG_PAINT_COLOR: regs.paint_color = cfg_data;
                    default: ;
                endcase
            end
            // Compare the result beat with the oldest prediction
            if (pop && !empty)
            begin
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: we %b addr %h colour %h",
                             $time, write_enable, address, color_out);
                    bad = 1'b1;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (write_enable !== want.we)
                    begin
                        report("write_enable", 32'(want.we), 32'(write_enable));
                        bad = 1'b1;
                    end
                    if (address !== want.addr)
                    begin
                        report("address", 32'(want.addr), 32'(address));
                        bad = 1'b1;
                    end
                    if (color_out !== want.color)
                    begin
                        report("color_out", want.color, color_out);
                        bad = 1'b1;
                    end
                    if (last_out !== want.last)
                    begin
                        report("last_out", 32'(want.last), 32'(last_out));
                        bad = 1'b1;
                    end
                end
            end
            // Predict the write for an accepted input beat
            if (push && !full)
                expected_writes.push_back(predict_pixel_write(regs, dest_x, dest_y, src_argb,
                                                              dst_pixel, last_in));
            outstanding <= expected_writes.size();
            if (bad)
                fail_count <= fail_count + 1;
        end
    end

endmodule

/* tb/sv/clipped_tinted_alpha_blit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_tinted_alpha_blit_tb - testbench top of the clipped tinted blitter
// Drives directed pixels at the clip and framebuffer edges in every mode,
// then phases of random pixels under random register settings, with random
// gaps on the input side and random stalls on the result side. A checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module clipped_tinted_alpha_blit_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 29;
    localparam int PHASE_PIXELS  = 50;
    localparam int SETTLE_CYCLES = 12;

    // Upper mode code, decoded as fill
    localparam logic [1:0] MODE_UPPER = 2'd3;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index    = ctab_pkg::REG_MODE;
    logic [31:0]        cfg_data     = '0;
    logic signed [13:0] dest_x       = '0;
    logic signed [13:0] dest_y       = '0;
    logic [31:0]        src_argb     = '0;
    logic [23:0]        dst_pixel    = '0;
    logic               last_in      = 1'b0;
    logic               push         = 1'b0;
    logic               full;
    logic               write_enable;
    logic [23:0]        address;
    logic [31:0]        color_out;
    logic               last_out;
    logic               empty;
    logic               pop          = 1'b0;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count  = 0;
    int                 push_style   = 1;
    int                 pop_style    = 1;
    ctab_pkg::cfg_t     current;

    always #5 clk = ~clk;

    clipped_tinted_alpha_blit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .dest_x(dest_x), .dest_y(dest_y), .src_argb(src_argb),
        .dst_pixel(dst_pixel), .last_in(last_in), .push(push), .full(full),
        .write_enable(write_enable), .address(address), .color_out(color_out),
        .last_out(last_out), .empty(empty), .pop(pop)
    );

    clipped_tinted_alpha_blit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .dest_x(dest_x), .dest_y(dest_y), .src_argb(src_argb),
        .dst_pixel(dst_pixel), .last_in(last_in), .push(push), .full(full),
        .write_enable(write_enable), .address(address), .color_out(color_out),
        .last_out(last_out), .empty(empty), .pop(pop),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("clipped_tinted_alpha_blit verification failed");
            $finish;
        end
    end

    // Style 0: no idling; 1: a random gap, possibly none; 2: mostly back to back
    function automatic int draw_gap(input int style);
        if (style == 0)
            return 0;
        if (style == 1)
            return $urandom_range(0, 14);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    endfunction

    // Take result beats, stalling at random
    initial
    begin : result_side
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(pop_style);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write the whole register set as back-to-back beats
    task automatic apply_config(input ctab_pkg::cfg_t c);
        put_reg(ctab_pkg::REG_MODE, 32'(c.mode));
        put_reg(ctab_pkg::REG_CLIP_MIN_X, 32'(c.clip_min_x));
        put_reg(ctab_pkg::REG_CLIP_MIN_Y, 32'(c.clip_min_y));
        put_reg(ctab_pkg::REG_CLIP_MAX_X, 32'(c.clip_max_x));
        put_reg(ctab_pkg::REG_CLIP_MAX_Y, 32'(c.clip_max_y));
        put_reg(ctab_pkg::REG_FRAME_WIDTH, 32'(c.frame_width));
        put_reg(ctab_pkg::REG_PAINT_COLOR, c.paint_color);
        cfg_valid <= 1'b0;
        current = c;
    endtask

    // Hold off until every predicted result has been taken
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic send_pixel(input logic signed [13:0] x, input logic signed [13:0] y,
                              input logic [31:0] src, input logic [23:0] dst,
                              input logic last);
        int gap;
        gap = draw_gap(push_style);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        dest_x    <= x;
        dest_y    <= y;
        src_argb  <= src;
        dst_pixel <= dst;
        last_in   <= last;
        push      <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    // Pick a coordinate near the clip window, the frame bounds or anywhere
    function automatic logic signed [13:0] pick_coord(input int lo, input int hi);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50 && lo <= hi)
            return 14'($urandom_range(lo, hi));
        if (sel < 65)
        begin
            case ($urandom_range(0, 3))
                0: return 14'(lo - 1);
                1: return 14'(lo);
                2: return 14'(hi);
                default: return 14'(hi + 1);
            endcase
        end
        if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0: return -14'sd1;
                1: return 14'sd4096;
                2: return -14'sd8192;
                default: return 14'sd8191;
            endcase
        end
        return 14'($urandom);
    endfunction

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_edge();
        case ($urandom_range(0, 3))
            0: return 12'd0;
            1: return 12'd4095;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic ctab_pkg::cfg_t random_config();
        ctab_pkg::cfg_t c;
        int sel;
        c.mode = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            // full frame
            c.clip_min_x = 12'd0;
            c.clip_min_y = 12'd0;
            c.clip_max_x = 12'd4095;
            c.clip_max_y = 12'd4095;
        end
        else if (sel < 8)
        begin
            // ordered window, small in half of the cases
            c.clip_min_x = 12'($urandom_range(0, 4095));
            c.clip_min_y = 12'($urandom_range(0, 4095));
            c.clip_max_x = 12'($urandom_range(c.clip_min_x, 4095));
            c.clip_max_y = 12'($urandom_range(c.clip_min_y, 4095));
            if ($urandom_range(0, 1) == 0)
            begin
                c.clip_max_x = (c.clip_min_x > 12'd4031) ? 12'd4095 : c.clip_min_x + 12'd64;
                c.clip_max_y = (c.clip_min_y > 12'd4031) ? 12'd4095 : c.clip_min_y + 12'd64;
            end
        end
        else
        begin
            // any edges, possibly crossed
            c.clip_min_x = pick_edge();
            c.clip_min_y = pick_edge();
            c.clip_max_x = pick_edge();
            c.clip_max_y = pick_edge();
        end
        case ($urandom_range(0, 7))
            0: c.frame_width = 13'd0;
            1: c.frame_width = 13'd8191;
            2: c.frame_width = 13'd4096;
            3: c.frame_width = 13'($urandom);
            default: c.frame_width = 13'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 5))
            0: c.paint_color = 32'h0000_0000;
            1: c.paint_color = 32'hffff_ffff;
            default: c.paint_color = $urandom;
        endcase
        return c;
    endfunction

    initial
    begin : stimulus
        ctab_pkg::cfg_t c;
        int   phase;
        int   n;

        current.mode        = ctab_pkg::MODE_BLEND;
        current.clip_min_x  = 12'd0;
        current.clip_min_y  = 12'd0;
        current.clip_max_x  = 12'd4095;
        current.clip_max_y  = 12'd4095;
        current.frame_width = 13'd4096;
        current.paint_color = 32'h00ff_ffff;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: opaque and clear source, frame bounds, coordinate extremes
        send_pixel(14'sd0, 14'sd0, 32'hff12_3456, 24'hffffff, 1'b0);
        send_pixel(14'sd4095, 14'sd4095, 32'h00ab_cdef, 24'h123456, 1'b0);
        send_pixel(-14'sd1, 14'sd0, 32'hffff_ffff, 24'h000000, 1'b0);
        send_pixel(14'sd4096, 14'sd5, 32'hffff_ffff, 24'h000000, 1'b0);
        send_pixel(-14'sd8192, 14'sd8191, 32'h8080_8080, 24'h808080, 1'b0);
        send_pixel(14'sd8191, -14'sd8192, 32'h8080_8080, 24'h808080, 1'b0);
        send_pixel(14'sd100, 14'sd200, 32'h80ff_00ff, 24'h00ff00, 1'b1);
        drain();

        // Black tint, small window, row length 1: probe each clip edge
        c.mode = ctab_pkg::MODE_BLEND;
        c.clip_min_x = 12'd10;
        c.clip_max_x = 12'd20;
        c.clip_min_y = 12'd30;
        c.clip_max_y = 12'd40;
        c.frame_width = 13'd1;
        c.paint_color = 32'h0000_0000;
        apply_config(c);
        send_pixel(14'sd9, 14'sd30, 32'h7fff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd10, 14'sd30, 32'h7fff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd20, 14'sd40, 32'h7fff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd21, 14'sd40, 32'h7fff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd15, 14'sd29, 32'h7fff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd15, 14'sd41, 32'h7fff_ffff, 24'hffffff, 1'b1);
        drain();

        // Plain copy, widest row: the address wraps
        c.mode = ctab_pkg::MODE_COPY;
        c.clip_min_x = 12'd0;
        c.clip_min_y = 12'd0;
        c.clip_max_x = 12'd4095;
        c.clip_max_y = 12'd4095;
        c.frame_width = 13'd8191;
        c.paint_color = 32'hffff_ffff;
        apply_config(c);
        send_pixel(14'sd4095, 14'sd4095, 32'hdead_beef, 24'h000000, 1'b0);
        send_pixel(14'sd0, 14'sd1, 32'h0000_0001, 24'hffffff, 1'b1);
        drain();

        // Solid fill with a zero row length
        c.mode = ctab_pkg::MODE_FILL;
        c.frame_width = 13'd0;
        c.paint_color = 32'hdead_beef;
        apply_config(c);
        send_pixel(14'sd5, 14'sd7, 32'h1234_5678, 24'habcdef, 1'b0);
        send_pixel(14'sd3, 14'sd3, 32'h0000_0000, 24'h000000, 1'b1);
        drain();

        // Upper mode code with crossed clip edges: nothing written
        c.mode = MODE_UPPER;
        c.clip_min_x = 12'd100;
        c.clip_max_x = 12'd50;
        c.frame_width = 13'd4096;
        apply_config(c);
        send_pixel(14'sd75, 14'sd10, 32'hffff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd100, 14'sd10, 32'hffff_ffff, 24'hffffff, 1'b0);
        send_pixel(14'sd50, 14'sd10, 32'hffff_ffff, 24'hffffff, 1'b1);
        drain();

        // Random phases, each under fresh register settings and idling styles
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_config(random_config());
            push_style = $urandom_range(0, 2);
            pop_style  = $urandom_range(0, 2);
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                send_pixel(pick_coord(current.clip_min_x, current.clip_max_x),
                           pick_coord(current.clip_min_y, current.clip_max_y),
                           {pick_alpha(), 24'($urandom)}, 24'($urandom),
                           ($urandom_range(0, 7) == 0));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("clipped_tinted_alpha_blit verification clean");
        else
            $display("clipped_tinted_alpha_blit verification failed");
        $finish;
    end

endmodule

/* clipped_tinted_alpha_blit.f */
design/ctab_pkg.sv
design/ctab_queue.sv
design/ctab_front.sv
design/ctab_back.sv
design/clipped_tinted_alpha_blit.sv
tb/sv/clipped_tinted_alpha_blit_checker.sv
tb/sv/clipped_tinted_alpha_blit_tb.sv
